// ===== rtl/core/aes_pkg.sv =====
// Shared types, constants and byte functions for the AES-128 encryption pipeline.
package aes_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] state;
    logic [BLOCK_W-1:0] rkey;
    logic [7:0]         rcon;
  } aes_stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // Byte 0 of a column sits in the top bits.
  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a, b, d, e, x;
    a = col[31:24];
    b = col[23:16];
    d = col[15:8];
    e = col[7:0];
    x = a ^ b ^ d ^ e;
    return {a ^ x ^ xtime(a ^ b), b ^ x ^ xtime(b ^ d),
            d ^ x ^ xtime(d ^ e), e ^ x ^ xtime(e ^ a)};
  endfunction

endpackage

// ===== rtl/core/aes128_block_encrypt.sv =====
// Top level of the pipelined AES-128 block encryption core.
//
// The key is written through the cfg_ port: index 0 loads key bytes 0 to 7,
// index 1 loads key bytes 8 to 15, and any other index is ignored. The port
// is always ready. Keys should only change while no request is in flight.
// Each request on the in_ channel carries one plaintext block; the out_
// channel returns its ciphertext. A request enters an input stage that adds
// the cipher key, then passes through a chain of ten round cells, each of
// which applies one round and derives the next round key from the key it
// receives. The result passes from the input stage through the ten round
// cell registers into the output register. With the receiver ready, one
// request is accepted every cycle.
// A skid stage behind the output register absorbs one result when the
// receiver stalls; once it is full the whole chain holds and in_tready falls
// until the receiver takes a result. Reset empties the chain and clears
// both key registers to zero.
module aes128_block_encrypt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]      cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [aes_pkg::BLOCK_W-1:0]     in_tdata,   // block_low, block_high
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [aes_pkg::BLOCK_W-1:0]     out_tdata   // cipher_low, cipher_high
);

  logic [aes_pkg::HALF_W-1:0]  key_high_r, key_high_nxt;
  logic [aes_pkg::HALF_W-1:0]  key_low_r, key_low_nxt;
  logic                        valid0_r;
  logic [aes_pkg::BLOCK_W-1:0] state0_r, rkey0_r;
  logic                        pipe_en;
  logic [aes_pkg::BLOCK_W-1:0] key, block, cipher;
  aes_pkg::aes_stage_t         chain [aes_pkg::NUM_ROUNDS+1];

  assign cfg_ready = 1'b1;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        aes_pkg::REG_KEY_HIGH: key_high_nxt = cfg_data;
        aes_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
    end
  end

  assign key   = {key_high_r, key_low_r};
  assign block = {in_tdata[63:0], in_tdata[127:64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (pipe_en) begin
      valid0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      state0_r <= block ^ key;
      rkey0_r  <= key;
    end
  end

  assign chain[0] = '{valid: valid0_r, state: state0_r, rkey: rkey0_r,
                      rcon: aes_pkg::RCON_FIRST};

  for (genvar i = 0; i < aes_pkg::NUM_ROUNDS; i++) begin : g_round
    aes_round_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .mix_en (i != aes_pkg::NUM_ROUNDS - 1),
      .d_i    (chain[i]),
      .q_o    (chain[i+1])
    );
  end

  aes_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain[aes_pkg::NUM_ROUNDS].valid),
    .in_data   (chain[aes_pkg::NUM_ROUNDS].state),
    .in_ready  (pipe_en),
    .out_valid (out_tvalid),
    .out_data  (cipher),
    .out_ready (out_tready)
  );

  assign in_tready = pipe_en;
  assign out_tdata = {cipher[63:0], cipher[127:64]};

endmodule

// ===== rtl/core/aes_round_cell.sv =====
// One cipher round with its round key expansion step, registered at the output.
module aes_round_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               mix_en,
  input  aes_pkg::aes_stage_t d_i,
  output aes_pkg::aes_stage_t q_o
);

  logic                        valid_r;
  logic [aes_pkg::BLOCK_W-1:0] state_r, state_nxt;
  logic [aes_pkg::BLOCK_W-1:0] rkey_r, rkey_nxt;
  logic [7:0]                  rcon_r, rcon_nxt;

  logic [7:0]  sb [16];
  logic [127:0] shifted, mixed;
  logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

  always_comb begin
    w0 = d_i.rkey[127:96];
    w1 = d_i.rkey[95:64];
    w2 = d_i.rkey[63:32];
    w3 = d_i.rkey[31:0];
    t  = {aes_pkg::sbox(w3[23:16]) ^ d_i.rcon, aes_pkg::sbox(w3[15:8]),
          aes_pkg::sbox(w3[7:0]), aes_pkg::sbox(w3[31:24])};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    rkey_nxt = {n0, n1, n2, n3};
    rcon_nxt = aes_pkg::xtime(d_i.rcon);

    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = aes_pkg::sbox(d_i.state[127 - 8*(((c + r) % 4)*4 + r) -: 8]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      shifted[127 - 8*i -: 8] = sb[i];
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = aes_pkg::mix_column(shifted[127 - 32*c -: 32]);
    end
    state_nxt = (mix_en ? mixed : shifted) ^ rkey_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      rkey_r  <= rkey_nxt;
      rcon_r  <= rcon_nxt;
    end
  end

  assign q_o = '{valid: valid_r, state: state_r, rkey: rkey_r, rcon: rcon_r};

endmodule

// ===== rtl/core/aes_out_buf.sv =====
// Output register with a skid stage that lets the round chain run while the receiver stalls, until the skid is full.
module aes_out_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [aes_pkg::BLOCK_W-1:0] in_data,
  output logic                        in_ready,
  output logic                        out_valid,
  output logic [aes_pkg::BLOCK_W-1:0] out_data,
  input  logic                        out_ready
);

  logic                        out_v_r, out_v_nxt;
  logic                        skid_v_r, skid_v_nxt;
  logic [aes_pkg::BLOCK_W-1:0] out_d_r, out_d_nxt;
  logic [aes_pkg::BLOCK_W-1:0] skid_d_r, skid_d_nxt;
  logic                        take, incoming;

  assign in_ready = !skid_v_r;
  assign take     = out_v_r && out_ready;
  assign incoming = in_valid && !skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (incoming) begin
      if (!out_v_r || take) begin
        out_d_nxt = in_data;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = in_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== rtl/core/aes_checker.sv =====
// Port-level checks on the AES-128 encryption core, bound to its top level.
module aes_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while the receiver stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held back with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input held back without a receiver stall");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/aes128_block_encrypt_test.sv =====
// Self-checking testbench for the AES-128 block encryption core, with its own cipher predictor.
module aes128_block_encrypt_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [aes_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd2;
  localparam logic [aes_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'hff;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct {
    logic [aes_pkg::HALF_W-1:0] high;
    logic [aes_pkg::HALF_W-1:0] low;
  } cipher_pair_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [aes_pkg::HALF_W-1:0]    cfg_data = '0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [aes_pkg::BLOCK_W-1:0]   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [aes_pkg::BLOCK_W-1:0]   out_tdata;

  logic [aes_pkg::HALF_W-1:0] key_high_q = '0;
  logic [aes_pkg::HALF_W-1:0] key_low_q = '0;
  logic [7:0]        sub_lut [256];
  cipher_pair_t      pending_ciphers [$];
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       hold_left = 0;
  logic              hold_start = 1'b0;

  always #5 clk = ~clk;

  aes128_block_encrypt i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  // The substitution table is derived from the field inverse and the affine map.
  task automatic build_sub_lut();
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      if (v == 0) inv = 8'h00;
      else for (int p = 0; p < 254; p++) inv = gf_mul(inv, 8'(v));
      sub_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                 ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  endtask

  function automatic logic [127:0] predict_cipher(input logic [127:0] key,
                                                  input logic [127:0] plain);
    logic [7:0] w [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] tw [4];
    logic [7:0] rc, f, a, b, d, e, x;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      w[i] = key[127-8*i -: 8];
      s[i] = plain[127-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = w[(i-1)*4 + j];
      if ((i % 4) == 0) begin
        f = tw[0];
        tw[0] = sub_lut[tw[1]] ^ rc;
        tw[1] = sub_lut[tw[2]];
        tw[2] = sub_lut[tw[3]];
        tw[3] = sub_lut[f];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) w[i*4 + j] = w[(i-4)*4 + j] ^ tw[j];
    end
    for (int i = 0; i < 16; i++) s[i] ^= w[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[c*4 + r] = sub_lut[s[((c + r) % 4)*4 + r]];
      if (rnd < 10) begin
        for (int c = 0; c < 16; c += 4) begin
          a = t[c];
          b = t[c+1];
          d = t[c+2];
          e = t[c+3];
          x = a ^ b ^ d ^ e;
          t[c]   = a ^ x ^ gf_double(a ^ b);
          t[c+1] = b ^ x ^ gf_double(b ^ d);
          t[c+2] = d ^ x ^ gf_double(d ^ e);
          t[c+3] = e ^ x ^ gf_double(e ^ a);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[rnd*16 + i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %016h expected %016h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] pick_word();
    int k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << k;
      3: return ~(64'd1 << k);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cipher_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ciphers.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], 64'h0);
      end else begin
        want = pending_ciphers.pop_front();
        if (out_tdata[63:0] !== want.high)
          report_mismatch("cipher_high", out_tdata[63:0], want.high);
        if (out_tdata[127:64] !== want.low)
          report_mismatch("cipher_low", out_tdata[127:64], want.low);
      end
    end
    if (!rst_n || hold_start || hold_left > 1) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_block(input logic [63:0] high, input logic [63:0] low);
    logic [127:0] res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {low, high};
    do @(posedge clk); while (!in_tready);
    res = predict_cipher({key_high_q, key_low_q}, {high, low});
    pending_ciphers.push_back('{high: res[127:64], low: res[63:0]});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_ciphers.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aes_pkg::CFG_IDX_W-1:0] index,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == aes_pkg::REG_KEY_HIGH) key_high_q = value;
    else if (index == aes_pkg::REG_KEY_LOW) key_low_q = value;
  endtask

  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    wait_idle();
  endtask

  task automatic test_known_answer();
    logic [127:0] res;
    write_reg(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    res = predict_cipher({key_high_q, key_low_q}, 128'h00112233445566778899aabbccddeeff);
    if (res !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
      report_mismatch("predictor vector", res[127:64], 64'h69c4e0d86a7b0430);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_idle();
    // Writes to indexes outside the key registers must leave the key untouched.
    write_reg(REG_UNUSED_FIRST, '1);
    write_reg(REG_UNUSED_LAST, 64'h5a5a5a5a5a5a5a5a);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    wait_idle();
  endtask

  task automatic test_key_extremes();
    write_reg(aes_pkg::REG_KEY_HIGH, '1);
    write_reg(aes_pkg::REG_KEY_LOW, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    wait_idle();
    write_reg(aes_pkg::REG_KEY_HIGH, '0);
    send_block('0, '1);
    send_block(64'h0000000000000001, 64'h8000000000000000);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(aes_pkg::REG_KEY_HIGH, pick_word());
    write_reg(aes_pkg::REG_KEY_LOW, pick_word());
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_idle();
        write_reg(aes_pkg::REG_KEY_HIGH, pick_word());
        write_reg(aes_pkg::REG_KEY_LOW, pick_word());
      end
      send_block(pick_word(), pick_word());
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start <= 1'b1;
    send_block(pick_word(), pick_word());
    hold_start <= 1'b0;
    for (int n = 0; n < 40; n++) send_block(pick_word(), pick_word());
    wait_idle();
  endtask

  initial begin
    build_sub_lut();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_key();
    test_known_answer();
    test_key_extremes();
    test_random_traffic(31, 78, 360);
    test_random_traffic(78, 31, 360);
    test_random_traffic(0, 0, 360);
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
